// ----- design/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define MFBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MFBP_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mfbp_pkg.sv -----
// shared types and constants of the msb-first bit packer
`timescale 1ns / 1ps

package mfbp_pkg;

  localparam int BYTE_W       = 8;
  localparam int PART_W       = 7;
  localparam int FILL_W       = 3;
  localparam int FIELD_BITS_W = 6;
  localparam int VALUE_W      = 32;

  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;
  localparam logic [PART_W-1:0] PART_MASK = 7'h7f;

  typedef enum logic [0:0] {
    OP_APPEND = 1'b0,
    OP_ALIGN  = 1'b1
  } op_t;

endpackage

// ----- design/mfbp_if.sv -----
// channel interfaces: input items and output bytes
`timescale 1ns / 1ps

interface mfbp_in_if;
  logic                                 valid;
  logic                                 ready;
  mfbp_pkg::op_t                        operation;
  logic [mfbp_pkg::FIELD_BITS_W-1:0]    field_bits;
  logic [mfbp_pkg::VALUE_W-1:0]         field_value;

  modport source (output valid, operation, field_bits, field_value, input ready);
  modport sink   (input valid, operation, field_bits, field_value, output ready);
endinterface

interface mfbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [mfbp_pkg::BYTE_W-1:0]   out_byte;
  logic                          last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ----- design/msb_first_bit_packer_top.sv -----
// top level of the msb-first bit packer
//
//   channel   dir  payload                                   handshake
//   in_ch     in   operation, field_bits, field_value        valid / ready
//   out_ch    out  out_byte, last_byte                       valid / ready
//
// an item is taken every cycle while the two-entry job queue has room
// an item that completes k bytes yields k bytes on out_ch, one byte per cycle from the
// back end while the output is not stalled; items that complete no byte queue no job
// first byte of an item passes through the job queue and the back end's output register
// synchronous active-low reset clears the partial byte, queue and output
// a stalled output holds its byte while the front keeps filling the queue
`timescale 1ns / 1ps

module msb_first_bit_packer_top #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  mfbp_in_if.sink     in_ch,
  mfbp_out_if.source  out_ch
);

  localparam int ACC_W     = MAX_FIELD_BITS + mfbp_pkg::PART_W;
  localparam int MAX_BYTES = ACC_W / 8;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int JOB_W     = ACC_W + CNT_W;

  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  logic [ACC_W-1:0]  job_data;
  logic [CNT_W-1:0]  job_cnt;
  logic [JOB_W-1:0]  head;

  mfbp_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .queue_full (full),
    .push       (push),
    .job_data   (job_data),
    .job_cnt    (job_cnt)
  );

  mfbp_fifo #(
    .WIDTH(JOB_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({job_cnt, job_data}),
    .pop       (pop),
    .head_data (head),
    .full      (full),
    .empty     (empty)
  );

  mfbp_back #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head_data (head[ACC_W-1:0]),
    .head_cnt  (head[JOB_W-1:ACC_W]),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ----- design/mfbp_front.sv -----
// front end: accepts items, merges them with the partial byte, queues byte jobs
`timescale 1ns / 1ps

module mfbp_front #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  mfbp_in_if.sink            in_ch,
  input  logic               queue_full,
  output logic               push,
  output logic [MAX_FIELD_BITS+mfbp_pkg::PART_W-1:0]  job_data,
  output logic [$clog2((MAX_FIELD_BITS+mfbp_pkg::PART_W)/8+1)-1:0] job_cnt
);

  localparam int ACC_W  = MAX_FIELD_BITS + mfbp_pkg::PART_W;
  localparam int MAX_BYTES = ACC_W / 8;
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);
  localparam int SAT_W  = $clog2(MAX_FIELD_BITS + 1);
  localparam int N_W    = (SAT_W > mfbp_pkg::FIELD_BITS_W) ? SAT_W : mfbp_pkg::FIELD_BITS_W;
  localparam int T_W    = N_W + 1;

  logic [mfbp_pkg::PART_W-1:0] partial_r, partial_nxt;
  logic [mfbp_pkg::FILL_W-1:0] fill_r, fill_nxt;

  logic              accept;
  logic [N_W-1:0]    fb_ext;
  logic [N_W-1:0]    n_sat;
  logic [T_W-1:0]    total;
  logic [mfbp_pkg::FILL_W-1:0] rem;
  logic [ACC_W-1:0]  val_masked;
  logic [ACC_W-1:0]  combined;
  logic [mfbp_pkg::BYTE_W-1:0] pad_byte;
  logic [ACC_W-1:0]  data_c;
  logic [CNT_W-1:0]  cnt_c;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    fb_ext     = N_W'(in_ch.field_bits);
    n_sat      = (fb_ext > N_W'(MAX_FIELD_BITS)) ? N_W'(MAX_FIELD_BITS) : fb_ext;
    total      = T_W'(fill_r) + T_W'(n_sat);
    rem        = total[mfbp_pkg::FILL_W-1:0];
    // bits at or above the value field width come in as zeros
    val_masked = ACC_W'(in_ch.field_value) & ~({ACC_W{1'b1}} << n_sat);
    combined   = (ACC_W'(partial_r) << n_sat) | val_masked;
    pad_byte   = mfbp_pkg::BYTE_W'({1'b0, partial_r} << (4'd8 - {1'b0, fill_r}))
                 & mfbp_pkg::BYTE_MASK;

    if (in_ch.operation == mfbp_pkg::OP_ALIGN) begin
      data_c      = ACC_W'(pad_byte);
      cnt_c       = (fill_r != '0) ? CNT_W'(1) : '0;
      partial_nxt = '0;
      fill_nxt    = '0;
    end else begin
      // completed bytes sit right-aligned once the leftover bits are dropped
      data_c      = combined >> rem;
      cnt_c       = CNT_W'(total >> 3);
      partial_nxt = mfbp_pkg::PART_W'(combined & ~({ACC_W{1'b1}} << rem))
                    & mfbp_pkg::PART_MASK;
      fill_nxt    = rem;
    end
  end

  assign push     = accept && (cnt_c != '0);
  assign job_data = data_c;
  assign job_cnt  = cnt_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      fill_r    <= '0;
    end else if (accept) begin
      partial_r <= partial_nxt;
      fill_r    <= fill_nxt;
    end
  end

endmodule

// ----- design/mfbp_fifo.sv -----
// two-entry job queue between front and back
`timescale 1ns / 1ps

module mfbp_fifo #(
  parameter int WIDTH = 42
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign empty     = (count_r == 2'd0);
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/mfbp_back.sv -----
// back end: unloads queued jobs one byte per unstalled cycle into the output register
`timescale 1ns / 1ps

module mfbp_back #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  logic [MAX_FIELD_BITS+mfbp_pkg::PART_W-1:0] head_data,
  input  logic [$clog2((MAX_FIELD_BITS+mfbp_pkg::PART_W)/8+1)-1:0] head_cnt,
  output logic               pop,
  mfbp_out_if.source         out_ch
);

  localparam int ACC_W     = MAX_FIELD_BITS + mfbp_pkg::PART_W;
  localparam int MAX_BYTES = ACC_W / 8;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  logic [ACC_W-1:0]            data_r, data_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [mfbp_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                        last_r, last_nxt;

  logic                        slot_free;
  logic                        active;
  logic                        fire;
  logic [ACC_W-1:0]            src_data;
  logic [CNT_W-1:0]            src_cnt;
  logic [CNT_W-1:0]            cnt_dec;

  always_comb begin
    slot_free = !out_valid_r || out_ch.ready;
    active    = (cnt_r != '0);
    src_data  = active ? data_r : head_data;
    src_cnt   = active ? cnt_r : head_cnt;
    cnt_dec   = src_cnt - CNT_W'(1);
    // a fresh job emits its first byte in the cycle it leaves the queue
    fire      = slot_free && (active || !empty);
    pop       = slot_free && !active && !empty;

    data_nxt      = data_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    last_nxt      = last_r;
    if (fire) begin
      data_nxt      = src_data;
      cnt_nxt       = cnt_dec;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = mfbp_pkg::BYTE_W'(src_data >> {cnt_dec, 3'b000});
      last_nxt      = (cnt_dec == '0);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    out_byte_r <= out_byte_nxt;
    last_r     <= last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = last_r;

endmodule

// ----- design/mfbp_checker.sv -----
// port-level checker for the bit packer and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfbp_checker #(
  parameter int MAX_FIELD_BITS = 32
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_operation,
  input logic [mfbp_pkg::FIELD_BITS_W-1:0] in_field_bits,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mfbp_pkg::BYTE_W-1:0]       out_byte,
  input logic                              last_byte
);

  localparam int SAT_W = $clog2(MAX_FIELD_BITS + 1);
  localparam int N_W   = (SAT_W > mfbp_pkg::FIELD_BITS_W) ? SAT_W : mfbp_pkg::FIELD_BITS_W;
  localparam int T_W   = N_W + 1;

  logic [mfbp_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]                  pending_r, pending_nxt;
  logic [N_W-1:0]              fb_ext;
  logic [N_W-1:0]              n_sat;
  logic [T_W-1:0]              total;
  logic [7:0]                  nb;
  logic                        in_acc;
  logic                        out_acc;

  // expected byte count tracked from the input transactions
  always_comb begin
    in_acc  = in_valid && in_ready;
    out_acc = out_valid && out_ready;
    fb_ext  = N_W'(in_field_bits);
    n_sat   = (fb_ext > N_W'(MAX_FIELD_BITS)) ? N_W'(MAX_FIELD_BITS) : fb_ext;
    total   = T_W'(fill_r) + T_W'(n_sat);
    if (in_operation == mfbp_pkg::OP_ALIGN) begin
      nb       = (fill_r != '0) ? 8'd1 : 8'd0;
      fill_nxt = '0;
    end else begin
      nb       = 8'(total >> 3);
      fill_nxt = total[mfbp_pkg::FILL_W-1:0];
    end
    pending_nxt = pending_r + (in_acc ? nb : 8'd0) - 8'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      pending_r <= '0;
    end else begin
      if (in_acc) begin
        fill_r <= fill_nxt;
      end
      pending_r <= pending_nxt;
    end
  end

  `MFBP_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_valid, "output valid after reset")
  `MFBP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte), "stalled output changed")
  `MFBP_ASSERT(a_no_extra_byte, clk, rst_n, out_acc |-> pending_r != 8'd0, "byte delivered that no item caused")
  `MFBP_ASSERT(a_last_marked, clk, rst_n, out_acc && pending_r == 8'd1 |-> last_byte, "final outstanding byte not marked last")

endmodule

bind msb_first_bit_packer_top mfbp_checker #(
  .MAX_FIELD_BITS(MAX_FIELD_BITS)
) u_mfbp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_operation  (in_ch.operation),
  .in_field_bits (in_ch.field_bits),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .last_byte     (out_ch.last_byte)
);

// ----- tb/msb_first_bit_packer_checker.sv -----
// bit packer checker: watches both channels, predicts the byte stream and compares
`timescale 1ns / 1ps

module msb_first_bit_packer_checker #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  mfbp_in_if   in_ch,
  mfbp_out_if  out_ch,
  output int   fail_count,
  output int   pending_bytes
);

  typedef struct packed {
    logic [mfbp_pkg::BYTE_W-1:0] data;
    logic                        last;
  } stream_byte_t;

  stream_byte_t                expected_bytes[$];
  stream_byte_t                head;
  logic [mfbp_pkg::PART_W-1:0] part_bits;
  logic [mfbp_pkg::FILL_W-1:0] part_fill;
  int                          errors;

  initial begin
    errors    = 0;
    part_bits = '0;
    part_fill = '0;
  end

  // shift one item into the packing state and queue the bytes it completes
  task automatic pack_item(input mfbp_pkg::op_t op,
                           input logic [mfbp_pkg::FIELD_BITS_W-1:0] nb,
                           input logic [mfbp_pkg::VALUE_W-1:0] val);
    logic [mfbp_pkg::BYTE_W-1:0] acc;
    logic [mfbp_pkg::BYTE_W-1:0] made[$];
    logic                        bit_in;
    int                          fill;
    int                          width;
    acc  = {1'b0, part_bits};
    fill = part_fill;
    if (op == mfbp_pkg::OP_APPEND) begin
      width = (nb > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(nb);
      for (int i = width; i > 0; i--) begin
        // positions beyond the value field shift in as zero
        bit_in = (i - 1 < mfbp_pkg::VALUE_W) ? val[i-1] : 1'b0;
        acc    = {acc[mfbp_pkg::BYTE_W-2:0], bit_in};
        fill++;
        if (fill == mfbp_pkg::BYTE_W) begin
          made.push_back(acc);
          acc  = '0;
          fill = 0;
        end
      end
    end else if (fill != 0) begin
      made.push_back(acc << (mfbp_pkg::BYTE_W - fill));
      acc  = '0;
      fill = 0;
    end
    foreach (made[k]) expected_bytes.push_back('{made[k], k == made.size() - 1});
    part_bits = acc[mfbp_pkg::PART_W-1:0];
    part_fill = mfbp_pkg::FILL_W'(fill);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      part_bits = '0;
      part_fill = '0;
      expected_bytes.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        pack_item(in_ch.operation, in_ch.field_bits, in_ch.field_value);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: expected none, actual %02h", out_ch.out_byte);
          errors++;
        end else begin
          head = expected_bytes.pop_front();
          if (out_ch.out_byte !== head.data) begin
            $error("out_byte: expected %02h, actual %02h", head.data, out_ch.out_byte);
            errors++;
          end
          if (out_ch.last_byte !== head.last) begin
            $error("last_byte: expected %0b, actual %0b", head.last, out_ch.last_byte);
            errors++;
          end
        end
      end
    end
    fail_count    <= errors;
    pending_bytes <= expected_bytes.size();
  end

endmodule

// ----- tb/msb_first_bit_packer_top_test.sv -----
// bit packer testbench top: clock, reset, stimulus, output stalls and verdict
`timescale 1ns / 1ps

module msb_first_bit_packer_top_test;

  localparam int MAX_FIELD_BITS = 32;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int PHASE_ITEMS    = 103;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending_bytes;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  mfbp_in_if  in_ch();
  mfbp_out_if out_ch();

  msb_first_bit_packer_top #(.MAX_FIELD_BITS(MAX_FIELD_BITS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  msb_first_bit_packer_checker #(.MAX_FIELD_BITS(MAX_FIELD_BITS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_bytes (pending_bytes)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // one transaction, with random idle cycles ahead of it
  task automatic send_item(input mfbp_pkg::op_t op,
                           input logic [mfbp_pkg::FIELD_BITS_W-1:0] nb,
                           input logic [mfbp_pkg::VALUE_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.field_bits  <= nb;
    in_ch.field_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    int                                pick;
    mfbp_pkg::op_t                     op;
    logic [mfbp_pkg::FIELD_BITS_W-1:0] nb;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      op   = (pick < 15) ? mfbp_pkg::OP_ALIGN : mfbp_pkg::OP_APPEND;
      if (pick < 15)
        nb = mfbp_pkg::FIELD_BITS_W'($urandom_range(0, 63));
      else if (pick < 25)
        nb = mfbp_pkg::FIELD_BITS_W'($urandom_range(MAX_FIELD_BITS + 1, 63));
      else if (pick < 35)
        nb = mfbp_pkg::FIELD_BITS_W'($urandom_range(0, 3));
      else
        nb = mfbp_pkg::FIELD_BITS_W'($urandom_range(1, MAX_FIELD_BITS));
      send_item(op, nb, $urandom());
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= mfbp_pkg::OP_APPEND;
    in_ch.field_bits  <= '0;
    in_ch.field_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero width, aligned align, extremes, masking, saturation
    send_item(mfbp_pkg::OP_APPEND, 6'd0,  32'hffff_ffff);
    send_item(mfbp_pkg::OP_ALIGN,  6'd0,  32'h0);
    send_item(mfbp_pkg::OP_APPEND, 6'd1,  32'h1);
    send_item(mfbp_pkg::OP_APPEND, 6'd7,  32'h7f);
    send_item(mfbp_pkg::OP_APPEND, 6'd32, 32'hffff_ffff);
    send_item(mfbp_pkg::OP_APPEND, 6'd32, 32'h0);
    send_item(mfbp_pkg::OP_APPEND, 6'd4,  32'hffff_fff5);
    send_item(mfbp_pkg::OP_ALIGN,  6'd63, 32'hffff_ffff);
    send_item(mfbp_pkg::OP_APPEND, 6'd3,  32'h5);
    send_item(mfbp_pkg::OP_APPEND, 6'd63, 32'ha5a5_a5a5);
    send_item(mfbp_pkg::OP_APPEND, 6'd33, 32'h1234_5678);
    send_item(mfbp_pkg::OP_APPEND, 6'd32, 32'h8000_0001);
    send_item(mfbp_pkg::OP_ALIGN,  6'd0,  32'h0);
    send_item(mfbp_pkg::OP_APPEND, 6'd8,  32'hc3);
    send_item(mfbp_pkg::OP_APPEND, 6'd31, 32'h7fff_ffff);
    send_item(mfbp_pkg::OP_APPEND, 6'd1,  32'h0);
    send_item(mfbp_pkg::OP_ALIGN,  6'd32, 32'h0);
    send_item(mfbp_pkg::OP_APPEND, 6'd7,  32'h0);
    send_item(mfbp_pkg::OP_APPEND, 6'd2,  32'h3);
    send_item(mfbp_pkg::OP_ALIGN,  6'd0,  32'h0);

    send_random(PHASE_ITEMS);
    send_idle_pct = 45;
    send_random(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 45;
    send_random(PHASE_ITEMS);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    send_random(PHASE_ITEMS);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
